@@ src/lsvc_pkg.sv @@
// Types and constants shared by the level-set volume conserver.
// No dependencies; every other file imports this package.
package lsvc_pkg;

	localparam int FRACTION_BITS = 13;
	localparam int UNIT_ONE      = 1 << FRACTION_BITS;
	localparam int SHIFT_LIMIT   = (3 * UNIT_ONE) / 100;
	localparam int PHI_LIMIT     = 2 * UNIT_ONE;

	localparam int PHI_W   = 16;
	localparam int WIDE_W  = PHI_W + 2;
	localparam int FRAC_W  = FRACTION_BITS + 1;
	localparam int VOL_W   = 32;
	localparam int SHIFT_W = 9;

	localparam int DIV_STEPS = FRACTION_BITS - 1;
	localparam int QUO_SAT   = 8;
	localparam int SAT_SH    = DIV_STEPS - QUO_SAT;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] MODE_MEASURE = 2'd0;
	localparam logic [1:0] MODE_APPLY   = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic acc;
		logic close;
		logic take_target;
		logic report_now;
		logic apply;
		logic div_init;
		logic div_step;
		logic report_div;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic target_valid;
		logic target_zero;
	} stat_t;

endpackage

@@ src/lsvc_stream_if.sv @@
// Sample and result channels of the level-set volume conserver.
// Depends on lsvc_pkg for field widths.
interface lsvc_sample_if;
	import lsvc_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic signed [PHI_W-1:0] phi_in;
	logic                    last_sample;

	modport source(output valid, mode, phi_in, last_sample, input ready);
	modport sink(input valid, mode, phi_in, last_sample, output ready);
endinterface

interface lsvc_result_if;
	import lsvc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [PHI_W-1:0]   phi_out;
	logic [VOL_W-1:0]          volume;
	logic signed [SHIFT_W-1:0] shift_value;
	logic                      is_volume_report;

	modport source(output valid, phi_out, volume, shift_value, is_volume_report, input ready);
	modport sink(input valid, phi_out, volume, shift_value, is_volume_report, output ready);
endinterface

@@ src/lsvc_ctrl.sv @@
// Controller of the volume conserver: handshakes, pass end and shift division sequencing.
// Depends on lsvc_pkg.
module lsvc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [1:0]    in_mode,
	input  logic          in_last,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	input  lsvc_pkg::stat_t stat,
	output lsvc_pkg::cmd_t  cmd
);
	import lsvc_pkg::*;

	state_t             state_q;
	state_t             state_nx;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_vld_q;
	logic               out_free;
	logic               fire;
	logic               measure_end;
	logic               load_out;

	assign out_free    = !out_vld_q || out_ready;
	assign in_ready    = (state_q == ST_RUN) && out_free;
	assign fire        = in_valid && in_ready;
	assign measure_end = fire && (in_mode == MODE_MEASURE) && in_last;
	assign out_valid   = out_vld_q;
	assign load_out    = cmd.apply || cmd.report_now || cmd.report_div;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_RUN: begin
				if (measure_end && stat.target_valid && !stat.target_zero)
					state_nx = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS))
					state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_nx = ST_RUN;
			end
			default: state_nx = ST_RUN;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_RUN: begin
				cmd.acc         = fire && (in_mode == MODE_MEASURE);
				cmd.close       = measure_end;
				cmd.take_target = measure_end && !stat.target_valid;
				cmd.report_now  = measure_end && (!stat.target_valid || stat.target_zero);
				cmd.apply       = fire && (in_mode == MODE_APPLY);
				cmd.clear       = fire && (in_mode == MODE_CLEAR);
			end
			ST_DIV: begin
				cmd.div_init = (cnt_q == '0);
				cmd.div_step = (cnt_q != '0);
			end
			ST_DONE: begin
				cmd.report_div = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (load_out)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

endmodule

@@ src/lsvc_datapath.sv @@
// Datapath of the volume conserver: volume sum, target, shift divider and result register.
// Depends on lsvc_pkg; driven by commands from lsvc_ctrl.
module lsvc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsvc_pkg::cmd_t                    cmd,
	output lsvc_pkg::stat_t                   stat,
	input  logic signed [lsvc_pkg::PHI_W-1:0] phi_in,
	output logic signed [lsvc_pkg::PHI_W-1:0] phi_out,
	output logic [lsvc_pkg::VOL_W-1:0]        volume,
	output logic signed [lsvc_pkg::SHIFT_W-1:0] shift_value,
	output logic                              is_volume_report
);
	import lsvc_pkg::*;

	localparam logic signed [WIDE_W-1:0] ONE_W = WIDE_W'(UNIT_ONE);
	localparam logic signed [WIDE_W-1:0] LIM_W = WIDE_W'(PHI_LIMIT);

	logic [VOL_W-1:0]          sum_q;
	logic [VOL_W-1:0]          target_q;
	logic                      tvalid_q;
	logic signed [SHIFT_W-1:0] shift_q;
	logic [VOL_W-1:0]          vol_q;
	logic                      neg_q;
	logic                      sat_q;
	logic [VOL_W-1:0]          rem_q;
	logic [DIV_STEPS-1:0]      quo_q;

	logic signed [WIDE_W-1:0]  phi_w;
	logic signed [WIDE_W-1:0]  frac_d;
	logic [FRAC_W-1:0]         frac;
	logic [VOL_W:0]            sum_wide;
	logic [VOL_W-1:0]          sum_nx;
	logic signed [WIDE_W-1:0]  app_d;
	logic signed [PHI_W-1:0]   app_phi;
	logic [VOL_W-1:0]          dmag;
	logic [VOL_W:0]            rem2;
	logic                      lim;
	logic [SHIFT_W-1:0]        mag;
	logic signed [SHIFT_W-1:0] div_shift;

	assign phi_w  = {{(WIDE_W-PHI_W){phi_in[PHI_W-1]}}, phi_in};
	assign frac_d = ONE_W - phi_w;

	always_comb begin
		if (frac_d < 0)
			frac = '0;
		else if (frac_d > LIM_W)
			frac = FRAC_W'(UNIT_ONE);
		else
			frac = frac_d[FRAC_W:1];
	end

	assign sum_wide = {1'b0, sum_q} + (VOL_W+1)'(frac);
	assign sum_nx   = sum_wide[VOL_W] ? '1 : sum_wide[VOL_W-1:0];

	assign app_d = phi_w - WIDE_W'(shift_q);

	always_comb begin
		if (shift_q == '0)
			app_phi = phi_in;
		else if (app_d > LIM_W)
			app_phi = PHI_W'(PHI_LIMIT);
		else if (app_d < -LIM_W)
			app_phi = PHI_W'(-PHI_LIMIT);
		else
			app_phi = app_d[PHI_W-1:0];
	end

	assign dmag = (target_q < vol_q) ? (vol_q - target_q) : (target_q - vol_q);
	assign rem2 = {rem_q, 1'b0};

	assign lim       = sat_q || (quo_q > DIV_STEPS'(SHIFT_LIMIT));
	assign mag       = lim ? SHIFT_W'(SHIFT_LIMIT) : quo_q[SHIFT_W-1:0];
	assign div_shift = neg_q ? -signed'(mag) : signed'(mag);

	assign stat.target_valid = tvalid_q;
	assign stat.target_zero  = (target_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			target_q <= '0;
			tvalid_q <= 1'b0;
			shift_q  <= '0;
		end else begin
			if (cmd.clear) begin
				sum_q    <= '0;
				target_q <= '0;
				tvalid_q <= 1'b0;
				shift_q  <= '0;
			end else begin
				if (cmd.acc)
					sum_q <= cmd.close ? '0 : sum_nx;
				if (cmd.take_target) begin
					target_q <= sum_nx;
					tvalid_q <= 1'b1;
				end
				if (cmd.report_now)
					shift_q <= '0;
				else if (cmd.report_div)
					shift_q <= div_shift;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close)
			vol_q <= sum_nx;
		if (cmd.div_init) begin
			neg_q <= target_q < vol_q;
			sat_q <= {dmag, SAT_SH'(0)} >= {SAT_SH'(0), target_q};
			rem_q <= dmag;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem2 >= {1'b0, target_q}) begin
				rem_q <= VOL_W'(rem2 - {1'b0, target_q});
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
			end else begin
				rem_q <= rem2[VOL_W-1:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
			end
		end
		if (cmd.apply) begin
			phi_out          <= app_phi;
			volume           <= '0;
			shift_value      <= shift_q;
			is_volume_report <= 1'b0;
		end else if (cmd.report_now) begin
			phi_out          <= '0;
			volume           <= sum_nx;
			shift_value      <= '0;
			is_volume_report <= 1'b1;
		end else if (cmd.report_div) begin
			phi_out          <= '0;
			volume           <= vol_q;
			shift_value      <= div_shift;
			is_volume_report <= 1'b1;
		end
	end

endmodule

@@ src/level_set_volume_conserver.sv @@
// Level-set volume conserver: measure and apply passes over a Q2.13 distance field.
// Measure and apply samples: one per cycle while the output is free; an apply result is
// registered in the next cycle. A closing measure sample with a stored nonzero target
// runs the 12-step shift divider and holds the input until the divider report is loaded.
// arst_n clears the sum, target, target flag, level shift and the output valid.
// Depends on lsvc_pkg, lsvc_stream_if, lsvc_ctrl and lsvc_datapath.
module level_set_volume_conserver (
	input  logic          clk,
	input  logic          arst_n,
	lsvc_sample_if.sink   sample,
	lsvc_result_if.source result
);
	import lsvc_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lsvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_mode  (sample.mode),
		.in_last  (sample.last_sample),
		.in_ready (sample.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	lsvc_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.phi_in          (sample.phi_in),
		.phi_out         (result.phi_out),
		.volume          (result.volume),
		.shift_value     (result.shift_value),
		.is_volume_report(result.is_volume_report)
	);

endmodule
